@@ src/stack_machine_execute_unit_defines.svh @@
// assertion macros for the stack machine execute unit
// used by the controller and the top level
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
// property that must hold whenever reset is released
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property that must hold at every edge, reset included
`define SME_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ src/sme_pkg.sv @@
// shared types and opcode constants for the stack machine execute unit
// no dependencies
`timescale 1ns / 1ps
package sme_pkg;
    localparam logic [4:0] OP_PUSH  = 5'd0;
    localparam logic [4:0] OP_ADD   = 5'd1;
    localparam logic [4:0] OP_SUB   = 5'd2;
    localparam logic [4:0] OP_MUL   = 5'd3;
    localparam logic [4:0] OP_DIV   = 5'd4;
    localparam logic [4:0] OP_EQ    = 5'd5;
    localparam logic [4:0] OP_LT    = 5'd6;
    localparam logic [4:0] OP_GT    = 5'd7;
    localparam logic [4:0] OP_LTE   = 5'd8;
    localparam logic [4:0] OP_GTE   = 5'd9;
    localparam logic [4:0] OP_LOAD  = 5'd10;
    localparam logic [4:0] OP_STORE = 5'd11;
    localparam logic [4:0] OP_JMP   = 5'd12;
    localparam logic [4:0] OP_JIF   = 5'd13;
    localparam logic [4:0] OP_PRINT = 5'd14;
    localparam logic [4:0] OP_INPUT = 5'd15;
    localparam logic [4:0] OP_HALT  = 5'd16;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
    localparam logic [1:0] ERR_DIVZERO   = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic latch_in;    // capture instruction
        logic cap_ops;     // capture operands from ram
        logic div_start;
        logic commit;      // write results and update state
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic div_done;
    } status_t;
endpackage

@@ src/stack_machine_execute_unit.sv @@
// stack machine execute unit: each instruction steps through read, capture and commit,
// with a divide wait for div (the divider retires one quotient bit per cycle); one instruction at a time
// rst_n is asynchronous active low: stack empty, pc zero, variables read zero
// the variable store uses per-entry valid bits so no clearing pass is needed
// depends on sme_pkg, sme_controller, sme_datapath
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_COUNT   = 256,
    parameter int PC_BITS     = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  req_type,
    input  logic [31:0] immediate,
    input  logic [7:0]  var_index,
    input  logic [31:0] input_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc,
    output logic        print_valid,
    output logic [31:0] print_value,
    output logic        halted_now,
    output logic [1:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    sme_pkg::cmd_t    cmd;
    sme_pkg::status_t status;
    logic pv_comb;
    logic pv_reg;

    assign cfg_ready = 1'b1;

    sme_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status));

    sme_datapath #(.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT), .PC_BITS(PC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .req_type(req_type),
        .immediate(immediate), .var_index(var_index), .input_value(input_value),
        .cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data), .next_pc(next_pc),
        .print_valid(pv_comb), .print_value(print_value), .halted_now(halted_now),
        .error_code(error_code));

    // registered print flag, aligned with the other result fields
    always_ff @(posedge clk)
    begin
        if (cmd.commit) pv_reg <= pv_comb;
    end
    assign print_valid = pv_reg;

    `SME_ASSERT(a_err_halts, out_valid && error_code != sme_pkg::ERR_NONE |-> halted_now, "error without halt")
    `SME_ASSERT(a_print_no_err, out_valid && print_valid |-> error_code == sme_pkg::ERR_NONE, "print with error")
    `SME_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")
endmodule

@@ src/sme_ram.sv @@
// generic single write, single registered read ram
// no dependencies
`timescale 1ns / 1ps
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/sme_divider.sv @@
// iterative signed 32-bit divider, one quotient bit per cycle, truncating
// no dependencies
`timescale 1ns / 1ps
module sme_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [31:0] rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, rem_sh} - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (~dividend + 32'd1) : dividend;
            dvs_next  = divisor[31] ? (~divisor + 32'd1) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;
endmodule

@@ src/sme_datapath.sv @@
// datapath: operand stack, variable store, alu, divider, pc and halt state
// depends on sme_pkg, sme_ram, sme_divider
`timescale 1ns / 1ps
module sme_datapath #(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_COUNT   = 256,
    parameter int PC_BITS     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sme_pkg::cmd_t       cmd,
    output sme_pkg::status_t    status,
    input  logic [4:0]          req_type,
    input  logic [31:0]         immediate,
    input  logic [7:0]          var_index,
    input  logic [31:0]         input_value,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_data,
    output logic [15:0]         next_pc,
    output logic                print_valid,
    output logic [31:0]         print_value,
    output logic                halted_now,
    output logic [1:0]          error_code
);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VA = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    logic [4:0]  op_reg;
    logic [31:0] imm_reg, inval_reg, a_reg, b_reg;
    logic [7:0]  vidx_reg;
    logic [15:0] len_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic halt_reg, halt_next;
    logic [VAR_COUNT-1:0] vvalid_reg;

    logic [31:0] s_top, s_sec, v_rd, q;
    logic [SA-1:0] ra_top, ra_sec, s_wa;
    logic s_we;
    logic [31:0] s_wd;
    logic v_we;
    logic [VA-1:0] v_addr;

    logic [CW-1:0] cnt_m1, cnt_m2;
    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m2 = cnt_reg - CW'(2);
    // two read copies of the stack give top and second in one read
    assign ra_top = cnt_m1[SA-1:0];
    assign ra_sec = cnt_m2[SA-1:0];

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk0 (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(ra_top), .rdata(s_top));
    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk1 (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(ra_sec), .rdata(s_sec));

    assign v_addr = VA'(vidx_reg);
    sme_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_vars (
        .clk(clk), .we(v_we), .waddr(v_addr), .wdata(b_reg), .raddr(v_addr), .rdata(v_rd));

    // operands come straight from the stack reads, captured in the same cycle
    sme_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(s_sec),
        .divisor(s_top), .done(status.div_done), .quotient(q));

    assign status.is_div = (op_reg == sme_pkg::OP_DIV);

    logic [PC_BITS-1:0] seq_pc;
    logic [31:0] res, push_v, prod;
    logic vidx_ok, pre_halt;
    logic [1:0] err;
    logic [32:0] len_ext;
    logic sa_lt;

    assign vidx_ok  = ({24'd0, vidx_reg} < VAR_COUNT);
    assign len_ext  = 33'(len_reg);
    assign pre_halt = (33'(pc_reg) >= len_ext);
    assign sa_lt    = $signed(a_reg) < $signed(b_reg);
    assign prod     = a_reg * b_reg;

    always_comb
    begin
        unique case (op_reg)
            sme_pkg::OP_PUSH, sme_pkg::OP_JMP, sme_pkg::OP_JIF:
                seq_pc = pc_reg + PC_BITS'(5);
            sme_pkg::OP_LOAD, sme_pkg::OP_STORE: seq_pc = pc_reg + PC_BITS'(2);
            default: seq_pc = pc_reg + PC_BITS'(1);
        endcase
        case (op_reg)
            sme_pkg::OP_ADD: res = a_reg + b_reg;
            sme_pkg::OP_SUB: res = a_reg - b_reg;
            sme_pkg::OP_MUL: res = prod;
            sme_pkg::OP_DIV: res = q;
            sme_pkg::OP_EQ:  res = {31'd0, a_reg == b_reg};
            sme_pkg::OP_LT:  res = {31'd0, sa_lt};
            sme_pkg::OP_GT:  res = {31'd0, !sa_lt && a_reg != b_reg};
            sme_pkg::OP_LTE: res = {31'd0, sa_lt || a_reg == b_reg};
            default:         res = {31'd0, !sa_lt};
        endcase
        case (op_reg)
            sme_pkg::OP_PUSH:  push_v = imm_reg;
            sme_pkg::OP_INPUT: push_v = inval_reg;
            default: push_v = (vidx_ok && vvalid_reg[v_addr]) ? v_rd : 32'd0;
        endcase
    end

    always_comb
    begin
        logic [PC_BITS-1:0] nx;
        logic halt_after;
        nx = seq_pc;
        halt_after = 1'b0;
        err = sme_pkg::ERR_NONE;
        s_we = 1'b0;
        s_wa = ra_sec;
        s_wd = res;
        v_we = 1'b0;
        cnt_next = cnt_reg;
        pc_next = pc_reg;
        halt_next = halt_reg;
        print_valid = 1'b0;
        if (!halt_reg && pre_halt)
        begin
            halt_next = 1'b1;
        end
        else if (!halt_reg)
        begin
            if (op_reg >= sme_pkg::OP_ADD && op_reg <= sme_pkg::OP_GTE)
            begin
                if (cnt_reg < CW'(2)) err = sme_pkg::ERR_UNDERFLOW;
                else if (op_reg == sme_pkg::OP_DIV && b_reg == 32'd0)
                begin
                    err = sme_pkg::ERR_DIVZERO;
                    cnt_next = cnt_m2;
                end
                else
                begin
                    cnt_next = cnt_m1;
                    s_we = 1'b1;
                end
            end
            else if (op_reg == sme_pkg::OP_PUSH || op_reg == sme_pkg::OP_LOAD
                     || op_reg == sme_pkg::OP_INPUT)
            begin
                if (cnt_reg >= CW'(STACK_DEPTH)) err = sme_pkg::ERR_OVERFLOW;
                else
                begin
                    s_we = 1'b1;
                    s_wa = cnt_reg[SA-1:0];
                    s_wd = push_v;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            else if (op_reg == sme_pkg::OP_STORE || op_reg == sme_pkg::OP_JIF
                     || op_reg == sme_pkg::OP_PRINT)
            begin
                if (cnt_reg == '0) err = sme_pkg::ERR_UNDERFLOW;
                else
                begin
                    cnt_next = cnt_m1;
                    if (op_reg == sme_pkg::OP_STORE) v_we = vidx_ok;
                    else if (op_reg == sme_pkg::OP_JIF)
                    begin
                        if (b_reg == 32'd0) nx = imm_reg[PC_BITS-1:0];
                    end
                    else print_valid = 1'b1;
                end
            end
            else if (op_reg == sme_pkg::OP_JMP) nx = imm_reg[PC_BITS-1:0];
            else if (op_reg == sme_pkg::OP_HALT) halt_after = 1'b1;
            if (err != sme_pkg::ERR_NONE) halt_next = 1'b1;
            else
            begin
                pc_next = nx;
                if (halt_after || (33'(nx) >= len_ext)) halt_next = 1'b1;
            end
        end
        s_we = s_we && cmd.commit;
        v_we = v_we && cmd.commit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            pc_reg     <= '0;
            halt_reg   <= 1'b0;
            len_reg    <= '0;
            vvalid_reg <= '0;
        end
        else
        begin
            if (cfg_we) len_reg <= cfg_data;
            if (cmd.commit)
            begin
                cnt_reg  <= cnt_next;
                pc_reg   <= pc_next;
                halt_reg <= halt_next;
                if (v_we) vvalid_reg[v_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= req_type;
            imm_reg   <= immediate;
            vidx_reg  <= var_index;
            inval_reg <= input_value;
        end
        if (cmd.cap_ops)
        begin
            // single pop ops take the top as b
            a_reg <= s_sec;
            b_reg <= s_top;
        end
        if (cmd.commit)
        begin
            next_pc     <= 16'(pc_next);
            print_value <= print_valid ? b_reg : 32'd0;
            halted_now  <= halt_next;
            error_code  <= err;
        end
    end
endmodule

@@ src/sme_controller.sv @@
// controller: sequences fetch, operand read, divide wait and commit
// depends on sme_pkg and the defines header
`timescale 1ns / 1ps
`include "stack_machine_execute_unit_defines.svh"
module sme_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output sme_pkg::cmd_t    cmd,
    input  sme_pkg::status_t status
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_CAP, S_DIV, S_COMMIT} state_t;
    state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_ops = 1'b1;
                state_next = S_COMMIT;
                if (status.is_div)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done) state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // result register must be free before it is overwritten
                if (!ov_next)
                begin
                    cmd.commit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CAP && status.is_div) cmd.div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    `SME_ASSERT(a_commit_free, cmd.commit |-> !(ov_reg && out_stall), "commit over held result")
    `SME_ASSERT(a_div_only, (state_reg == S_DIV) |-> status.is_div, "divide wait without div")
    `SME_ASSERT(a_accept_idle, (in_valid && !in_stall) |=> (state_reg == S_READ), "accept lost")
endmodule
